// File: hdl/prds_pkg.sv
`default_nettype none
package prds_pkg;
	localparam int MaxTasks = 16;
	localparam int TaskBits = 4;
	localparam int FillBits = 5;
	localparam int PrioBits = 4;
	localparam int DelayBits = 16;
	localparam logic [PrioBits-1:0] PrioBest = 4'd1;
	localparam logic [PrioBits-1:0] PrioWorst = 4'd8;

	typedef enum logic [2:0] {
		OP_ENQ_READY = 3'd0,
		OP_ENQ_DELAY = 3'd1,
		OP_DISPATCH  = 3'd2,
		OP_TICK      = 3'd3,
		OP_RERUN     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_READY_FULL = 2'd1,
		ST_DELAY_FULL = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RSCAN,
		S_RSHIFT,
		S_WSCAN,
		S_WSHIFT,
		S_POP,
		S_DEC,
		S_TSCAN,
		S_TREMOVE,
		S_TINS,
		S_DONE
	} state_t;

	// one compare request to the shared comparator
	typedef struct packed {
		logic [DelayBits-1:0] a_ticks;
		logic [DelayBits-1:0] b_ticks;
		logic [PrioBits-1:0]  a_prio;
		logic [PrioBits-1:0]  b_prio;
	} cmp_req_t;

	typedef struct packed {
		logic le_prio;   // a_prio <= b_prio
		logic wait_pass; // a before b in the delay queue order
		logic zero;      // a_ticks == 0
	} cmp_rsp_t;

	function automatic logic [PrioBits-1:0] clamp_prio(input logic [PrioBits-1:0] p);
		if (p < PrioBest) return PrioBest;
		if (p > PrioWorst) return PrioWorst;
		return p;
	endfunction
endpackage
`default_nettype wire

// File: hdl/prds_cmp.sv
`default_nettype none
module prds_cmp (
	input  wire prds_pkg::cmp_req_t req,
	output prds_pkg::cmp_rsp_t      rsp
);
	always_comb begin
		rsp.le_prio   = req.a_prio <= req.b_prio;
		rsp.wait_pass = (req.a_ticks > req.b_ticks) ||
			((req.a_ticks == req.b_ticks) && (req.a_prio > req.b_prio));
		rsp.zero      = req.a_ticks == '0;
	end
endmodule
`default_nettype wire

// File: hdl/priority_ready_delay_scheduler_unit.sv
`default_nettype none
// Task scheduler with a priority-sorted ready queue and a tick-sorted delay queue of
// 16 entries each. One operation is taken at a time; ready drops while it runs. Each
// step of the sequencer moves or compares one queue entry, and every compare goes
// through a single shared comparator, so an enqueue or a dispatch walks its queue
// entry by entry, and a tick walks the delay queue to decrement and to scan it and,
// for each expired entry, runs a removal walk and a sorted insertion.
// The result beat is held in an output register until taken.
module priority_ready_delay_scheduler_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [2:0] op,
	input  wire  [3:0] task_req,
	input  wire  [3:0] priority_req,
	input  wire  [15:0] delay,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       dispatched_valid,
	output logic [3:0] dispatched_task,
	output logic [4:0] ready_count,
	output logic [4:0] delay_count,
	output logic [1:0] status
);
	localparam int TB = prds_pkg::TaskBits;
	localparam int FB = prds_pkg::FillBits;
	localparam int PB = prds_pkg::PrioBits;
	localparam int DB = prds_pkg::DelayBits;
	localparam int N  = prds_pkg::MaxTasks;
	localparam logic [FB-1:0] FullCnt = FB'(N);

	prds_pkg::state_t state_q, state_d;

	logic [TB-1:0] rtask_q [N];
	logic [PB-1:0] rprio_q [N];
	logic [FB-1:0] rfill_q;
	logic [TB-1:0] wtask_q [N];
	logic [PB-1:0] wprio_q [N];
	logic [DB-1:0] wticks_q [N];
	logic [FB-1:0] wfill_q;
	logic [PB-1:0] rec_prio_q [N];
	logic [N-1:0]  known_q;
	logic [TB-1:0] run_task_q;
	logic          run_valid_q;

	logic [2:0]    op_q;
	logic [TB-1:0] task_q;
	logic [PB-1:0] prio_q;
	logic [DB-1:0] ticks_q;
	logic [FB-1:0] idx_q;  // scan position / shift position
	logic [FB-1:0] pos_q;  // found insertion position
	logic [FB-1:0] j_q;    // tick walk position
	logic          tick_q; // ready insert is part of a tick
	logic [1:0]    st_q;
	logic          dv_q;
	logic [TB-1:0] dt_q;

	prds_pkg::cmp_req_t req;
	prds_pkg::cmp_rsp_t rsp;
	prds_cmp u_cmp (.req(req), .rsp(rsp));

	logic [TB-1:0] idx;
	logic [TB-1:0] idxm1;
	logic [TB-1:0] jm1;
	logic [PB-1:0] task_prio;
	assign idx   = idx_q[TB-1:0];
	assign idxm1 = TB'(idx_q - FB'(1));
	assign jm1   = TB'(j_q - FB'(1));
	assign task_prio = known_q[task_q] ? rec_prio_q[task_q] : prds_pkg::PrioBest;

	always_comb begin
		req = '0;
		case (state_q)
			prds_pkg::S_RSCAN: begin
				req.a_prio = rprio_q[idx];
				req.b_prio = prio_q;
			end
			prds_pkg::S_WSCAN: begin
				req.a_ticks = wticks_q[idx];
				req.b_ticks = ticks_q;
				req.a_prio  = wprio_q[idx];
				req.b_prio  = prio_q;
			end
			prds_pkg::S_TSCAN: req.a_ticks = wticks_q[jm1];
			default: req = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			prds_pkg::S_IDLE: if (in_valid && in_ready) state_d = prds_pkg::S_DECODE;
			prds_pkg::S_DECODE: begin
				case (op_q)
					prds_pkg::OP_ENQ_READY: state_d = (rfill_q >= FullCnt) ?
						prds_pkg::S_DONE : prds_pkg::S_RSCAN;
					prds_pkg::OP_ENQ_DELAY, prds_pkg::OP_RERUN: begin
						if (op_q == prds_pkg::OP_RERUN && !run_valid_q) state_d = prds_pkg::S_DONE;
						else if (ticks_q == '0) state_d = (rfill_q >= FullCnt) ?
							prds_pkg::S_DONE : prds_pkg::S_RSCAN;
						else state_d = (wfill_q >= FullCnt) ?
							prds_pkg::S_DONE : prds_pkg::S_WSCAN;
					end
					prds_pkg::OP_DISPATCH: state_d = (rfill_q == '0) ?
						prds_pkg::S_DONE : prds_pkg::S_POP;
					prds_pkg::OP_TICK: state_d = prds_pkg::S_DEC;
					default: state_d = prds_pkg::S_DONE;
				endcase
			end
			prds_pkg::S_RSCAN: if (idx_q >= rfill_q || !rsp.le_prio) state_d = prds_pkg::S_RSHIFT;
			prds_pkg::S_RSHIFT: if (idx_q == pos_q)
				state_d = tick_q ? prds_pkg::S_TSCAN : prds_pkg::S_DONE;
			prds_pkg::S_WSCAN: if (idx_q >= wfill_q || !rsp.wait_pass) state_d = prds_pkg::S_WSHIFT;
			prds_pkg::S_WSHIFT: if (idx_q == pos_q) state_d = prds_pkg::S_DONE;
			prds_pkg::S_POP: if (idx_q + FB'(1) >= rfill_q) state_d = prds_pkg::S_DONE;
			prds_pkg::S_DEC: if (idx_q >= wfill_q) state_d = prds_pkg::S_TSCAN;
			prds_pkg::S_TSCAN: begin
				if (j_q == '0) state_d = prds_pkg::S_DONE;
				else if (rsp.zero) state_d = prds_pkg::S_TREMOVE;
			end
			prds_pkg::S_TREMOVE: if (idx_q + FB'(1) >= wfill_q) state_d = prds_pkg::S_TINS;
			prds_pkg::S_TINS: state_d = (rfill_q >= FullCnt) ?
				prds_pkg::S_TSCAN : prds_pkg::S_RSCAN;
			prds_pkg::S_DONE: if (!out_valid || out_ready) state_d = prds_pkg::S_IDLE;
			default: state_d = prds_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == prds_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prds_pkg::S_IDLE;
			rfill_q     <= '0;
			wfill_q     <= '0;
			known_q     <= '0;
			run_valid_q <= 1'b0;
			run_task_q  <= '0;
			out_valid   <= 1'b0;
			tick_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new beat loaded in the done state keeps the output valid
			if (out_valid && out_ready && state_q != prds_pkg::S_DONE) out_valid <= 1'b0;
			case (state_q)
				prds_pkg::S_IDLE: if (in_valid) begin
					op_q    <= op;
					task_q  <= task_req;
					prio_q  <= prds_pkg::clamp_prio(priority_req);
					ticks_q <= delay;
					idx_q   <= '0;
					st_q    <= prds_pkg::ST_OK;
					dv_q    <= 1'b0;
					dt_q    <= '0;
					tick_q  <= 1'b0;
				end
				prds_pkg::S_DECODE: begin
					idx_q <= '0;
					case (op_q)
						prds_pkg::OP_ENQ_READY: if (rfill_q >= FullCnt) st_q <= prds_pkg::ST_READY_FULL;
						prds_pkg::OP_ENQ_DELAY, prds_pkg::OP_RERUN: begin
							if (op_q == prds_pkg::OP_RERUN && !run_valid_q) st_q <= prds_pkg::ST_EMPTY;
							else begin
								if (op_q == prds_pkg::OP_RERUN) begin
									task_q <= run_task_q;
									prio_q <= known_q[run_task_q] ? rec_prio_q[run_task_q] :
										prds_pkg::PrioBest;
								end else prio_q <= task_prio;
								if (ticks_q == '0) begin
									if (rfill_q >= FullCnt) st_q <= prds_pkg::ST_READY_FULL;
								end else if (wfill_q >= FullCnt) st_q <= prds_pkg::ST_DELAY_FULL;
							end
						end
						prds_pkg::OP_DISPATCH: begin
							if (rfill_q == '0) st_q <= prds_pkg::ST_EMPTY;
							else begin
								dv_q        <= 1'b1;
								dt_q        <= rtask_q[0];
								run_task_q  <= rtask_q[0];
								run_valid_q <= 1'b1;
							end
						end
						prds_pkg::OP_TICK: j_q <= wfill_q;
						default: ;
					endcase
				end
				prds_pkg::S_RSCAN: begin
					if (idx_q >= rfill_q || !rsp.le_prio) begin
						pos_q <= idx_q;
						idx_q <= rfill_q;
						if (!known_q[task_q]) begin
							known_q[task_q]    <= 1'b1;
							rec_prio_q[task_q] <= prio_q;
						end
					end else idx_q <= idx_q + FB'(1);
				end
				prds_pkg::S_RSHIFT: begin
					if (idx_q == pos_q) begin
						rtask_q[idx] <= task_q;
						rprio_q[idx] <= prio_q;
						rfill_q      <= rfill_q + FB'(1);
					end else begin
						rtask_q[idx] <= rtask_q[idxm1];
						rprio_q[idx] <= rprio_q[idxm1];
						idx_q        <= idx_q - FB'(1);
					end
				end
				prds_pkg::S_WSCAN: begin
					if (idx_q >= wfill_q || !rsp.wait_pass) begin
						pos_q <= idx_q;
						idx_q <= wfill_q;
					end else idx_q <= idx_q + FB'(1);
				end
				prds_pkg::S_WSHIFT: begin
					if (idx_q == pos_q) begin
						wtask_q[idx]  <= task_q;
						wprio_q[idx]  <= prio_q;
						wticks_q[idx] <= ticks_q;
						wfill_q       <= wfill_q + FB'(1);
					end else begin
						wtask_q[idx]  <= wtask_q[idxm1];
						wprio_q[idx]  <= wprio_q[idxm1];
						wticks_q[idx] <= wticks_q[idxm1];
						idx_q         <= idx_q - FB'(1);
					end
				end
				prds_pkg::S_POP: begin
					if (idx_q + FB'(1) >= rfill_q) rfill_q <= rfill_q - FB'(1);
					else begin
						rtask_q[idx] <= rtask_q[TB'(idx_q + FB'(1))];
						rprio_q[idx] <= rprio_q[TB'(idx_q + FB'(1))];
						idx_q        <= idx_q + FB'(1);
					end
				end
				prds_pkg::S_DEC: begin
					if (idx_q < wfill_q) begin
						wticks_q[idx] <= wticks_q[idx] - DB'(1);
						idx_q         <= idx_q + FB'(1);
					end
				end
				prds_pkg::S_TSCAN: begin
					tick_q <= 1'b0;
					if (j_q != '0) begin
						if (rsp.zero) begin
							task_q <= wtask_q[jm1];
							prio_q <= wprio_q[jm1];
							idx_q  <= j_q - FB'(1);
						end
						j_q <= j_q - FB'(1);
					end
				end
				prds_pkg::S_TREMOVE: begin
					if (idx_q + FB'(1) >= wfill_q) wfill_q <= wfill_q - FB'(1);
					else begin
						wtask_q[idx]  <= wtask_q[TB'(idx_q + FB'(1))];
						wprio_q[idx]  <= wprio_q[TB'(idx_q + FB'(1))];
						wticks_q[idx] <= wticks_q[TB'(idx_q + FB'(1))];
						idx_q         <= idx_q + FB'(1);
					end
				end
				prds_pkg::S_TINS: begin
					idx_q <= '0;
					if (rfill_q >= FullCnt) st_q <= prds_pkg::ST_READY_FULL;
					else tick_q <= 1'b1;
				end
				prds_pkg::S_DONE: if (!out_valid || out_ready) begin
					out_valid        <= 1'b1;
					dispatched_valid <= dv_q;
					dispatched_task  <= dt_q;
					ready_count      <= rfill_q;
					delay_count      <= wfill_q;
					status           <= st_q;
				end
				default: ;
			endcase
		end
	end

	// fill counts never pass the queue depth
	assert property (@(posedge clk) disable iff (!arst_n) rfill_q <= FullCnt && wfill_q <= FullCnt)
		else $error("queue fill beyond depth");
	// a dispatch beat is only shown while a task is running
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dispatched_valid |-> run_valid_q)
		else $error("dispatch without running task");
	// no new item while busy
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != prds_pkg::S_IDLE |-> !in_ready)
		else $error("ready while busy");
endmodule
`default_nettype wire

// File: bench/priority_ready_delay_scheduler_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module priority_ready_delay_scheduler_unit_test;

	typedef struct packed {
		logic       dv;
		logic [3:0] dt;
		logic [4:0] rc;
		logic [4:0] wc;
		logic [1:0] st;
	} sched_result_t;

	// scheduler state mirror and expected beats
	class sched_scoreboard;
		logic [3:0]  rdy_task [prds_pkg::MaxTasks];
		logic [3:0]  rdy_prio [prds_pkg::MaxTasks];
		int          rdy_n;
		logic [3:0]  dly_task [prds_pkg::MaxTasks];
		logic [3:0]  dly_prio [prds_pkg::MaxTasks];
		logic [15:0] dly_ticks [prds_pkg::MaxTasks];
		int          dly_n;
		logic [3:0]  first_prio [prds_pkg::MaxTasks];
		bit          prio_seen [prds_pkg::MaxTasks];
		logic [3:0]  cur_task;
		bit          cur_valid;
		sched_result_t pending[$];
		int          errors;

		function new();
			rdy_n = 0;
			dly_n = 0;
			cur_task = 0;
			cur_valid = 0;
			errors = 0;
			foreach (prio_seen[i]) begin
				prio_seen[i] = 0;
				first_prio[i] = 0;
			end
		endfunction

		function logic [3:0] prio_for(logic [3:0] t);
			return prio_seen[t] ? first_prio[t] : prds_pkg::PrioBest;
		endfunction

		function logic [1:0] rdy_put(logic [3:0] t, logic [3:0] p);
			int pos;
			if (rdy_n >= prds_pkg::MaxTasks) return prds_pkg::ST_READY_FULL;
			if (!prio_seen[t]) begin
				prio_seen[t] = 1;
				first_prio[t] = p;
			end
			pos = 0;
			while (pos < rdy_n && rdy_prio[pos] <= p) pos++;
			for (int i = rdy_n; i > pos; i--) begin
				rdy_task[i] = rdy_task[i-1];
				rdy_prio[i] = rdy_prio[i-1];
			end
			rdy_task[pos] = t;
			rdy_prio[pos] = p;
			rdy_n++;
			return prds_pkg::ST_OK;
		endfunction

		function logic [1:0] dly_put(logic [3:0] t, logic [3:0] p, logic [15:0] k);
			int pos;
			if (k == 0) return rdy_put(t, p);
			if (dly_n >= prds_pkg::MaxTasks) return prds_pkg::ST_DELAY_FULL;
			pos = 0;
			while (pos < dly_n && (dly_ticks[pos] > k ||
				(dly_ticks[pos] == k && dly_prio[pos] > p))) pos++;
			for (int i = dly_n; i > pos; i--) begin
				dly_task[i] = dly_task[i-1];
				dly_prio[i] = dly_prio[i-1];
				dly_ticks[i] = dly_ticks[i-1];
			end
			dly_task[pos] = t;
			dly_prio[pos] = p;
			dly_ticks[pos] = k;
			dly_n++;
			return prds_pkg::ST_OK;
		endfunction

		function logic [1:0] tick();
			logic [1:0] s;
			logic [3:0] t, p;
			int j;
			s = prds_pkg::ST_OK;
			for (int i = 0; i < dly_n; i++) dly_ticks[i] = dly_ticks[i] - 16'd1;
			j = dly_n;
			while (j > 0) begin
				j--;
				if (dly_ticks[j] == 0) begin
					t = dly_task[j];
					p = dly_prio[j];
					for (int q = j; q + 1 < dly_n; q++) begin
						dly_task[q] = dly_task[q+1];
						dly_prio[q] = dly_prio[q+1];
						dly_ticks[q] = dly_ticks[q+1];
					end
					dly_n--;
					if (rdy_put(t, p) != prds_pkg::ST_OK) s = prds_pkg::ST_READY_FULL;
				end
			end
			return s;
		endfunction

		function void note_beat(logic [2:0] o, logic [3:0] t, logic [3:0] pr, logic [15:0] d);
			sched_result_t r;
			r = '0;
			case (o)
				prds_pkg::OP_ENQ_READY: r.st = rdy_put(t, clamp(pr));
				prds_pkg::OP_ENQ_DELAY: r.st = dly_put(t, prio_for(t), d);
				prds_pkg::OP_DISPATCH: begin
					if (rdy_n == 0) r.st = prds_pkg::ST_EMPTY;
					else begin
						r.dt = rdy_task[0];
						r.dv = 1;
						for (int i = 0; i + 1 < rdy_n; i++) begin
							rdy_task[i] = rdy_task[i+1];
							rdy_prio[i] = rdy_prio[i+1];
						end
						rdy_n--;
						cur_task = r.dt;
						cur_valid = 1;
					end
				end
				prds_pkg::OP_TICK: r.st = tick();
				prds_pkg::OP_RERUN: begin
					if (!cur_valid) r.st = prds_pkg::ST_EMPTY;
					else r.st = dly_put(cur_task, prio_for(cur_task), d);
				end
				default: ;
			endcase
			r.rc = rdy_n[4:0];
			r.wc = dly_n[4:0];
			pending.push_back(r);
		endfunction

		function logic [3:0] clamp(logic [3:0] p);
			if (p < prds_pkg::PrioBest) return prds_pkg::PrioBest;
			if (p > prds_pkg::PrioWorst) return prds_pkg::PrioWorst;
			return p;
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		task check_beat(sched_result_t g);
			sched_result_t e;
			if (pending.size() == 0) begin
				report("unexpected result beat", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (g.dv !== e.dv) report("dispatched_valid", g.dv, e.dv);
			if (g.dt !== e.dt) report("dispatched_task", g.dt, e.dt);
			if (g.rc !== e.rc) report("ready_count", g.rc, e.rc);
			if (g.wc !== e.wc) report("delay_count", g.wc, e.wc);
			if (g.st !== e.st) report("status", g.st, e.st);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic [2:0] op = 0;
	logic [3:0] task_req = 0, priority_req = 0;
	logic [15:0] delay = 0;
	wire in_ready, out_valid, dispatched_valid;
	wire [3:0] dispatched_task;
	wire [4:0] ready_count, delay_count;
	wire [1:0] status;

	sched_scoreboard sb = new();
	int cycles = 0;
	int hold_off = 0;
	bit stalls_on = 1;

	priority_ready_delay_scheduler_unit DUT (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("priority_ready_delay_scheduler_unit_test: errors");
			$finish;
		end
	end

	// receiver: own stall pattern plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat({dispatched_valid, dispatched_task, ready_count, delay_count, status});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else if (!stalls_on) out_ready <= 1;
		else out_ready <= (cycles % 97 < 60) ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			sb.note_beat(op, task_req, priority_req, delay);

	task send_beat(logic [2:0] o, logic [3:0] t, logic [3:0] p, logic [15:0] d);
		in_valid <= 1;
		op <= o;
		task_req <= t;
		priority_req <= p;
		delay <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task idle_gap(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task random_beat(int mode);
		logic [2:0] o;
		logic [15:0] d;
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) o = prds_pkg::OP_ENQ_READY;
		else if (r < 40) o = prds_pkg::OP_ENQ_DELAY;
		else if (r < 62) o = prds_pkg::OP_DISPATCH;
		else if (r < 85) o = prds_pkg::OP_TICK;
		else if (r < 97) o = prds_pkg::OP_RERUN;
		else o = 3'($urandom_range(5, 7));
		case ($urandom_range(0, 9))
			0: d = 0;
			1: d = 16'($urandom);
			2: d = 16'hffff;
			default: d = 16'($urandom_range(1, mode ? 3 : 8));
		endcase
		send_beat(o, 4'($urandom), 4'($urandom), d);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty cases, clamping, unknown priority, extremes
		send_beat(prds_pkg::OP_DISPATCH, 0, 0, 0);
		send_beat(prds_pkg::OP_RERUN, 0, 0, 5);
		send_beat(prds_pkg::OP_ENQ_DELAY, 4'd15, 0, 16'd1);
		send_beat(prds_pkg::OP_ENQ_READY, 4'd3, 4'd0, 0);
		send_beat(prds_pkg::OP_ENQ_READY, 4'd4, 4'd15, 0);
		send_beat(prds_pkg::OP_ENQ_READY, 4'd5, 4'd8, 0);
		send_beat(prds_pkg::OP_ENQ_READY, 4'd3, 4'd6, 0);
		send_beat(prds_pkg::OP_ENQ_DELAY, 4'd4, 0, 16'd0);
		send_beat(prds_pkg::OP_ENQ_DELAY, 4'd5, 0, 16'd2);
		send_beat(prds_pkg::OP_ENQ_DELAY, 4'd3, 0, 16'd2);
		send_beat(prds_pkg::OP_ENQ_DELAY, 4'd0, 0, 16'hffff);
		send_beat(prds_pkg::OP_TICK, 0, 0, 0);
		send_beat(prds_pkg::OP_TICK, 0, 0, 0);
		send_beat(3'd7, 4'd9, 4'd9, 16'h5555);
		send_beat(prds_pkg::OP_DISPATCH, 0, 0, 0);
		send_beat(prds_pkg::OP_RERUN, 0, 0, 0);
		send_beat(prds_pkg::OP_RERUN, 0, 0, 16'd1);
		send_beat(3'd5, 0, 0, 0);
		send_beat(3'd6, 0, 0, 0);
		drain();
		// fill ready queue past full, then tick drops into full queue
		for (int i = 0; i < 17; i++) send_beat(prds_pkg::OP_ENQ_READY, 4'(i), 4'($urandom), 0);
		for (int i = 0; i < 17; i++) send_beat(prds_pkg::OP_ENQ_DELAY, 4'(i), 0, 16'd1);
		send_beat(prds_pkg::OP_TICK, 0, 0, 0);
		// long receiver hold-off while sender fills up
		hold_off = 400;
		for (int i = 0; i < 30; i++) begin
			send_beat(prds_pkg::OP_DISPATCH, 0, 0, 0);
			send_beat(prds_pkg::OP_TICK, 0, 0, 0);
		end
		drain();
		for (int n = 0; n < 640; ) begin
			int burst;
			burst = $urandom_range(1, 20);
			stalls_on = ($urandom_range(0, 4) != 0);
			for (int b = 0; b < burst; b++) begin
				random_beat(n % 200 < 100);
				n++;
			end
			if ($urandom_range(0, 9) == 0) drain();
			else if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 12));
		end
		drain();
		repeat (500) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("priority_ready_delay_scheduler_unit_test: clean");
		else
			$display("priority_ready_delay_scheduler_unit_test: errors");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
hdl/prds_pkg.sv
hdl/prds_cmp.sv
hdl/priority_ready_delay_scheduler_unit.sv
bench/priority_ready_delay_scheduler_unit_test.sv
